FILE: rtl/core/mskal_pkg.sv
// ----------------------------------------------------------------------------
// mskal_pkg
// Shared constants and types for the multichannel scalar Kalman core.
// ----------------------------------------------------------------------------
package mskal_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // field widths
    localparam int CH_W    = 2;
    localparam int MEAS_W  = 8;
    localparam int EST_W   = 16;
    localparam int VAR_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int DIFF_W  = 18;
    localparam int DELTA_W = 19;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // reset values
    localparam logic signed [EST_W-1:0] EST_RESET = -16'sd15360;  // -60.0 dB
    localparam logic [VAR_W-1:0] VAR_RESET = 16'd4096;              // 1.0
    localparam logic [VAR_W-1:0] Q_RESET   = 16'd512;               // 0.125
    localparam logic [VAR_W-1:0] R_RESET   = 16'd16384;             // 4.0

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 1'b1;

    typedef struct packed {
        logic             start;
        logic [VAR_W-1:0] pp;
        logic [VAR_W-1:0] r;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] k;
    } t_div_rsp;

    typedef struct packed {
        logic                     start;
        logic [GAIN_W-1:0]        k;
        logic signed [DIFF_W-1:0] diff;
        logic [VAR_W-1:0]         pp;
    } t_mul_req;

    typedef struct packed {
        logic                      done;
        logic signed [DELTA_W-1:0] delta;
        logic [VAR_W-1:0]          p_new;
    } t_mul_rsp;

endpackage

FILE: rtl/core/multichannel_scalar_kalman_core.sv
// ----------------------------------------------------------------------------
// multichannel_scalar_kalman_core
// Per-channel scalar Kalman smoothing of signal strength readings.
// ----------------------------------------------------------------------------
// One item is worked at a time; the next input beat is taken only after its result
// has been written to the output register. The work is done by two bit-serial
// 16-step passes (the divider answers at once when the measurement noise register
// is zero): a restoring divider forms the gain, then a shift-add unit forms the
// estimate correction and the new variance together.
// A finished result sits in an output register, so the next item can start
// while it waits; a new result is only written once that register is free.
// Configuration is always ready and is meant to be written while idle.
module multichannel_scalar_kalman_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [mskal_pkg::CH_W-1:0]              i_channel,
    input  logic signed [mskal_pkg::MEAS_W-1:0]     i_measurement,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [mskal_pkg::CH_W-1:0]              o_channel_out,
    output logic signed [mskal_pkg::EST_W-1:0]      o_estimate_out,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [mskal_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mskal_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import mskal_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [CH_W-1:0]           r_ch;
    logic signed [MEAS_W-1:0]  r_m;
    logic                      r_track;
    logic [VAR_W-1:0]          r_pp;
    logic signed [DIFF_W-1:0]  r_diff;
    logic [VAR_W-1:0]          r_qn;
    logic [VAR_W-1:0]          r_rn;
    logic                      r_out_valid;
    logic [CH_W-1:0]           r_out_ch;
    logic signed [EST_W-1:0]   r_out_est;

    logic signed [EST_W-1:0]   r_est [CHANNELS];
    logic [VAR_W-1:0]          r_var [CHANNELS];

    logic [CH_IDX_W-1:0]       idx;
    logic signed [EST_W-1:0]   est_cur;
    logic [VAR_W-1:0]          var_cur;
    logic [VAR_W:0]            pp_sum;
    logic [VAR_W-1:0]          pp_sat;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DELTA_W:0]   est_sum;
    logic signed [EST_W-1:0]   est_new;
    logic                      in_beat;
    logic                      out_free;

    t_div_req div_req;
    t_div_rsp div_rsp;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign idx      = CH_IDX_W'(r_ch);
    assign est_cur  = r_est[idx];
    assign var_cur  = r_var[idx];

    always_comb begin
        pp_sum = {1'b0, var_cur} + {1'b0, r_qn};
        pp_sat = pp_sum[VAR_W] ? '1 : pp_sum[VAR_W-1:0];
        diff   = DIFF_W'(signed'({r_m, 8'h00})) - DIFF_W'(est_cur);
        est_sum = (DELTA_W+1)'(est_cur) + (DELTA_W+1)'(mul_rsp.delta);
        if (est_sum > (DELTA_W+1)'(32767)) begin
            est_new = 16'sh7FFF;
        end else if (est_sum < -(DELTA_W+1)'(32768)) begin
            est_new = 16'sh8000;
        end else begin
            est_new = est_sum[EST_W-1:0];
        end
    end

    always_comb begin
        div_req.start = (r_state == S_LOAD) && r_track;
        div_req.pp    = pp_sat;
        div_req.r     = r_rn;
        mul_req.start = (r_state == S_DIV) && div_rsp.done;
        mul_req.k     = div_rsp.k;
        mul_req.diff  = r_diff;
        mul_req.pp    = r_pp;
    end

    mskal_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    mskal_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = r_track ? S_DIV : S_WB;
            end
            S_DIV: begin
                if (div_rsp.done) n_state = S_MUL;
            end
            S_MUL: begin
                if (mul_rsp.done) n_state = S_WB;
            end
            S_WB: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_qn        <= Q_RESET;
            r_rn        <= R_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                r_est[i] <= EST_RESET;
                r_var[i] <= VAR_RESET;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PROCESS_NOISE:     r_qn <= i_cfg_data;
                    CFG_MEASUREMENT_NOISE: r_rn <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_beat) begin
                r_ch    <= i_channel;
                r_m     <= i_measurement;
                r_track <= (32'(i_channel) < CHANNELS);
            end

            if (r_state == S_LOAD) begin
                r_pp   <= pp_sat;
                r_diff <= diff;
            end

            if (r_state == S_WB && out_free) begin
                r_out_valid <= 1'b1;
                r_out_ch    <= r_ch;
                if (r_track) begin
                    r_out_est  <= est_new;
                    r_est[idx] <= est_new;
                    r_var[idx] <= mul_rsp.p_new;
                end else begin
                    // untracked channel: no state change, zero estimate
                    r_out_est <= '0;
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_channel_out  = r_out_ch;
    assign o_estimate_out = r_out_est;
    assign o_cfg_ready    = 1'b1;

endmodule

FILE: rtl/core/mskal_div.sv
// ----------------------------------------------------------------------------
// mskal_div
// Bit-serial restoring divider for the gain K = P' * 65536 / (P' + r).
// ----------------------------------------------------------------------------
module mskal_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mskal_pkg::t_div_req i_req,
    output mskal_pkg::t_div_rsp o_rsp
);
    import mskal_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [3:0]          r_cnt;
    logic [VAR_W+1:0]    r_rem;
    logic [VAR_W:0]      r_den;
    logic [GAIN_W-1:0]   r_q;

    logic [VAR_W+1:0]    shifted;
    logic                q_bit;
    logic [VAR_W+1:0]    n_rem;

    // remainder always stays below the divisor, so shifted < 2 * den
    always_comb begin
        shifted = {r_rem[VAR_W:0], 1'b0};
        q_bit   = (shifted >= {1'b0, r_den});
        n_rem   = q_bit ? (shifted - {1'b0, r_den}) : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.r == '0) begin
                    // zero noise: gain saturates just below one, or is zero
                    r_q    <= (i_req.pp == '0) ? '0 : '1;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_rem  <= {2'b00, i_req.pp};
                    r_den  <= {1'b0, i_req.pp} + {1'b0, i_req.r};
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[GAIN_W-2:0], q_bit};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.k    = r_q;

endmodule

FILE: rtl/core/mskal_mul.sv
// ----------------------------------------------------------------------------
// mskal_mul
// Bit-serial shift-add multipliers for K * diff and P' * K, LSB of K first.
// ----------------------------------------------------------------------------
module mskal_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mskal_pkg::t_mul_req i_req,
    output mskal_pkg::t_mul_rsp o_rsp
);
    import mskal_pkg::*;

    logic                       r_busy;
    logic                       r_done;
    logic [3:0]                 r_cnt;
    logic [GAIN_W-1:0]          r_k;
    logic signed [DIFF_W-1:0]   r_diff;
    logic [VAR_W-1:0]           r_pp;
    logic signed [DELTA_W-1:0]  r_hi_e;
    logic [VAR_W-1:0]           r_hi_p;
    logic                       r_sticky;

    logic signed [DELTA_W-1:0]  t_e;
    logic [VAR_W:0]             t_p;

    always_comb begin
        t_e = r_hi_e + (r_k[0] ? {r_diff[DIFF_W-1], r_diff} : '0);
        t_p = {1'b0, r_hi_p} + (r_k[0] ? {1'b0, r_pp} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_k      <= i_req.k;
                r_diff   <= i_req.diff;
                r_pp     <= i_req.pp;
                r_hi_e   <= '0;
                r_hi_p   <= '0;
                r_sticky <= 1'b0;
                r_cnt    <= '0;
                r_busy   <= 1'b1;
            end else if (r_busy) begin
                // arithmetic shift keeps the running floor of the signed product
                r_hi_e   <= t_e >>> 1;
                r_hi_p   <= t_p[VAR_W:1];
                r_sticky <= r_sticky | t_p[0];
                r_k      <= {1'b0, r_k[GAIN_W-1:1]};
                r_cnt    <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // P' * (65536 - K) >> 16 = P' - ceil(P' * K / 65536)
    assign o_rsp.done  = r_done;
    assign o_rsp.delta = r_hi_e;
    assign o_rsp.p_new = r_pp - r_hi_p - {{(VAR_W-1){1'b0}}, r_sticky};

endmodule

FILE: rtl/core/mskal_chk.sv
// ----------------------------------------------------------------------------
// mskal_chk
// Port-level checks for the multichannel scalar Kalman core.
// ----------------------------------------------------------------------------
module mskal_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [mskal_pkg::CH_W-1:0]          o_channel_out,
    input logic signed [mskal_pkg::EST_W-1:0]  o_estimate_out
);

    // an accepted beat takes input ready low while the update begins
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready ##1 !o_in_ready)
        else $error("input ready again too soon after a beat");

    // a new result only appears as the block goes back to idle
    a_result_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result raised while an item is still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before its beat");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_channel_out) && $stable(o_estimate_out)))
        else $error("result changed while stalled");

endmodule

bind multichannel_scalar_kalman_core mskal_chk u_mskal_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_channel_out  (o_channel_out),
    .o_estimate_out (o_estimate_out)
);

FILE: tb/tb_multichannel_scalar_kalman_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multichannel_scalar_kalman_core
// Drives signal strength readings into the Kalman core under several noise
// settings, predicts each channel's new estimate from a local copy of the
// filter state and checks every result beat against it, in order.
// ----------------------------------------------------------------------------
module tb_multichannel_scalar_kalman_core;
    import mskal_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [CH_W-1:0]         channel;
        logic signed [EST_W-1:0] estimate;
    } t_estimate;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [CH_W-1:0]               i_channel = '0;
    logic signed [MEAS_W-1:0]      i_measurement = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [CH_W-1:0]               o_channel_out;
    logic signed [EST_W-1:0]       o_estimate_out;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;

    // local copy of the filter state and noise registers
    logic signed [EST_W-1:0] est_track [CHANNELS];
    logic [VAR_W-1:0]        var_track [CHANNELS];
    logic [VAR_W-1:0]        q_reg;
    logic [VAR_W-1:0]        r_reg;

    t_estimate pending_estimates[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        steady = 1'b0;

    multichannel_scalar_kalman_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_channel      (i_channel),
        .i_measurement  (i_measurement),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_channel_out  (o_channel_out),
        .o_estimate_out (o_estimate_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // one filter step: returns the new estimate and updates the local state
    function automatic logic signed [EST_W-1:0] predict_step(
        input logic [CH_W-1:0] ch,
        input logic signed [MEAS_W-1:0] meas
    );
        longint pp;
        longint den;
        longint gain;
        longint diff;
        longint est;
        if (ch >= CHANNELS) begin
            return '0;
        end
        pp = longint'(var_track[ch]) + longint'(q_reg);
        if (pp > 65535) begin
            pp = 65535;
        end
        den = pp + longint'(r_reg);
        if (den == 0) begin
            gain = 0;
        end else begin
            gain = (pp << 16) / den;
            if (gain > 65535) begin
                gain = 65535;
            end
        end
        est = longint'(est_track[ch]);
        diff = longint'(meas) * 256 - est;
        // arithmetic shift floors towards minus infinity
        est = est + ((gain * diff) >>> 16);
        if (est > 32767) begin
            est = 32767;
        end
        if (est < -32768) begin
            est = -32768;
        end
        est_track[ch] = est[EST_W-1:0];
        var_track[ch] = VAR_W'((pp * (65536 - gain)) >> 16);
        return est[EST_W-1:0];
    endfunction

    function automatic void note_mismatch(input string what, input longint want,
                                          input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what,
                     want, got);
        end
    endfunction

    // send one reading; returns at the edge where the beat is taken
    task automatic send_reading(input logic [CH_W-1:0] ch,
                                input logic signed [MEAS_W-1:0] meas);
        t_estimate next_est;
        if (!steady && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_channel     <= ch;
        i_measurement <= meas;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        next_est.channel  = ch;
        next_est.estimate = predict_step(ch, meas);
        pending_estimates.push_back(next_est);
    endtask

    // pause input until every outstanding estimate has come back
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both registers in back-to-back beats; block must be idle
    task automatic set_noise(input logic [VAR_W-1:0] q, input logic [VAR_W-1:0] r);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PROCESS_NOISE;
        i_cfg_data  <= q;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        q_reg = q;
        i_cfg_index <= CFG_MEASUREMENT_NOISE;
        i_cfg_data  <= r;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        r_reg = r;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_reading(2'd0, -8'sd128);
        send_reading(2'd1, 8'sd0);
        send_reading(2'd2, 8'sd127);
        send_reading(2'd3, -8'sd1);
        send_reading(2'd0, -8'sd60);
        send_reading(2'd1, -8'sd85);
        send_reading(2'd2, -8'sd128);
        send_reading(2'd3, 8'sd64);
        wait_for_drain();
    endtask

    // q at full scale drives P + q into saturation
    task automatic test_variance_saturation();
        set_noise(16'hFFFF, 16'hFFFF);
        send_reading(2'd0, -8'sd128);
        send_reading(2'd0, 8'sd127);
        send_reading(2'd2, -8'sd40);
        wait_for_drain();
        set_noise(16'hFFFF, 16'd1);
        send_reading(2'd1, -8'sd128);
        send_reading(2'd1, 8'sd0);
        send_reading(2'd3, 8'sd127);
        wait_for_drain();
    endtask

    // r = 0 saturates the gain and zeroes P; then q = 0 gives a zero denominator
    task automatic test_zero_noise();
        set_noise(Q_RESET, 16'd0);
        send_reading(2'd2, -8'sd70);
        send_reading(2'd2, -8'sd70);
        wait_for_drain();
        set_noise(16'd0, 16'd0);
        send_reading(2'd2, -8'sd30);
        send_reading(2'd2, -8'sd128);
        send_reading(2'd3, -8'sd50);
        wait_for_drain();
    endtask

    // per-channel levels that jump now and then, with jitter, plus some raw noise
    task automatic test_random_tracking();
        int               level [CHANNELS];
        logic [VAR_W-1:0] q;
        logic [VAR_W-1:0] r;
        logic [CH_W-1:0]  ch;
        foreach (level[i]) level[i] = -$urandom_range(30, 100);
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin q = Q_RESET; r = R_RESET; end
                1: begin q = 16'd0; r = 16'd1; end
                2: begin q = 16'hFFFF; r = 16'hFFFF; end
                3: begin q = 16'd0; r = 16'd0; end
                4: begin q = 16'($urandom); r = 16'($urandom); end
                default: begin
                    q = 16'($urandom_range(0, 2048));
                    r = 16'($urandom_range(0, 65535));
                end
            endcase
            set_noise(q, r);
            steady = (phase == 0);
            for (int n = 0; n < 125; n++) begin
                ch = CH_W'($urandom_range(CHANNELS - 1));
                if ($urandom_range(99) < 85) begin
                    if ($urandom_range(99) < 5) begin
                        level[ch] = -$urandom_range(30, 100);
                    end
                    send_reading(ch, MEAS_W'(level[ch] + $urandom_range(0, 12) - 6));
                end else begin
                    send_reading(ch, MEAS_W'($urandom_range(255)));
                end
            end
            steady = 1'b0;
            wait_for_drain();
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_estimate want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_estimates.size() == 0) begin
                    note_mismatch("unexpected beat, channel", -1, o_channel_out);
                end else begin
                    want = pending_estimates.pop_front();
                    if (o_channel_out !== want.channel) begin
                        note_mismatch("channel_out", want.channel, o_channel_out);
                    end
                    if (o_estimate_out !== want.estimate) begin
                        note_mismatch("estimate_out", want.estimate, o_estimate_out);
                    end
                end
            end
            i_out_ready <= steady || ($urandom_range(99) >= 10);
        end
    end

    // a stuck handshake ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            est_track[i] = EST_RESET;
            var_track[i] = VAR_RESET;
        end
        q_reg = Q_RESET;
        r_reg = R_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_variance_saturation();
        test_zero_noise();
        test_random_tracking();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mskal_pkg.sv
rtl/core/mskal_div.sv
rtl/core/mskal_mul.sv
rtl/core/multichannel_scalar_kalman_core.sv
rtl/core/mskal_chk.sv
tb/tb_multichannel_scalar_kalman_core.sv
